### rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared widths, result part codes and pipeline payload types for the
// triangle setup engine.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int CORNER_W   = 16;
  localparam int EDGE_W     = 17;
  localparam int PROD_W     = 34;
  localparam int VAL_W      = 35;
  localparam int MAG_W      = 34;
  localparam int HALF_W     = 17;
  localparam int DEN_W      = 70;
  localparam int REM_W      = 71;
  localparam int Q_W        = 33;
  localparam int MANT_W     = 32;
  localparam int LZ_W       = 7;
  localparam int EXP_W      = 7;
  localparam int PART_W     = 3;
  localparam int NORM_STEPS = 7;
  localparam int DIV_STEPS  = 33;
  localparam int EXP_BIAS   = 37;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [PART_W-1:0] PART_EDGE_AB = 3'd0;
  localparam logic [PART_W-1:0] PART_EDGE_AC = 3'd1;
  localparam logic [PART_W-1:0] PART_NORMAL  = 3'd2;
  localparam logic [PART_W-1:0] PART_DOTS    = 3'd3;
  localparam logic [PART_W-1:0] PART_RECIP   = 3'd4;

  typedef struct packed {
    logic signed [EDGE_W-1:0] ux;
    logic signed [EDGE_W-1:0] uy;
    logic signed [EDGE_W-1:0] uz;
    logic signed [EDGE_W-1:0] vx;
    logic signed [EDGE_W-1:0] vy;
    logic signed [EDGE_W-1:0] vz;
    logic                     fin;
  } tse_edges_t;

  typedef struct packed {
    tse_edges_t              e;
    logic signed [VAL_W-1:0] nx;
    logic signed [VAL_W-1:0] ny;
    logic signed [VAL_W-1:0] nz;
    logic signed [VAL_W-1:0] d11;
    logic signed [VAL_W-1:0] d12;
    logic signed [VAL_W-1:0] d22;
  } tse_early_t;

  typedef struct packed {
    tse_early_t       early;
    logic             deg;
    logic [DEN_W-1:0] den;
    logic [LZ_W-1:0]  lz;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } tse_div_t;

  typedef struct packed {
    tse_early_t              early;
    logic [MANT_W-1:0]       mant;
    logic signed [EXP_W-1:0] ex;
    logic                    deg;
  } tse_tri_t;

endpackage

### rtl/tse_if.sv
// ----------------------------------------------------------------------------
// tse_in_if / tse_out_if
// Valid/ready channels for corner input beats and result output beats.
// ----------------------------------------------------------------------------
interface tse_in_if;
  import tse_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [CORNER_W-1:0] corner_a_x;
  logic signed [CORNER_W-1:0] corner_a_y;
  logic signed [CORNER_W-1:0] corner_a_z;
  logic signed [CORNER_W-1:0] corner_b_x;
  logic signed [CORNER_W-1:0] corner_b_y;
  logic signed [CORNER_W-1:0] corner_b_z;
  logic signed [CORNER_W-1:0] corner_c_x;
  logic signed [CORNER_W-1:0] corner_c_y;
  logic signed [CORNER_W-1:0] corner_c_z;
  logic                       final_triangle;

  modport source (output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                  corner_b_z, corner_c_x, corner_c_y, corner_c_z, final_triangle,
                  input ready);
  modport sink (input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                corner_b_z, corner_c_x, corner_c_y, corner_c_z, final_triangle,
                output ready);
endinterface

interface tse_out_if;
  import tse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [PART_W-1:0]       part;
  logic signed [VAL_W-1:0] value_one;
  logic signed [VAL_W-1:0] value_two;
  logic signed [VAL_W-1:0] value_three;
  logic signed [EXP_W-1:0] scale_exponent;
  logic                    degenerate;
  logic                    batch_end;
  logic                    last_of_run;

  modport source (output valid, part, value_one, value_two, value_three, scale_exponent,
                  degenerate, batch_end, last_of_run, input ready);
  modport sink (input valid, part, value_one, value_two, value_three, scale_exponent,
                degenerate, batch_end, last_of_run, output ready);
endinterface

### rtl/tse_front.sv
// ----------------------------------------------------------------------------
// tse_front
// Accepts corner beats and forms the edge vectors AB and AC for the queue.
// ----------------------------------------------------------------------------
module tse_front (
  tse_in_if.sink                in_chan,
  input  logic                  q_full,
  output logic                  q_push,
  output tse_pkg::tse_edges_t   q_wdata
);
  import tse_pkg::*;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  always_comb begin
    q_wdata.ux  = EDGE_W'(in_chan.corner_b_x) - EDGE_W'(in_chan.corner_a_x);
    q_wdata.uy  = EDGE_W'(in_chan.corner_b_y) - EDGE_W'(in_chan.corner_a_y);
    q_wdata.uz  = EDGE_W'(in_chan.corner_b_z) - EDGE_W'(in_chan.corner_a_z);
    q_wdata.vx  = EDGE_W'(in_chan.corner_c_x) - EDGE_W'(in_chan.corner_a_x);
    q_wdata.vy  = EDGE_W'(in_chan.corner_c_y) - EDGE_W'(in_chan.corner_a_y);
    q_wdata.vz  = EDGE_W'(in_chan.corner_c_z) - EDGE_W'(in_chan.corner_a_z);
    q_wdata.fin = in_chan.final_triangle;
  end

endmodule

### rtl/tse_queue.sv
// ----------------------------------------------------------------------------
// tse_queue
// Short FIFO of edge sets between the front and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module tse_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tse_pkg::tse_edges_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                rvalid,
  output tse_pkg::tse_edges_t rdata
);
  import tse_pkg::*;

  tse_edges_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_pop;

  assign full   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (do_pop) rd_r <= rd_r + QPTR_W'(1);
      if (push && !do_pop) cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (!push && do_pop) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_r - rd_r) == cnt_r[QPTR_W-1:0]) else $error("queue pointers out of step");

endmodule

### rtl/tse_back.sv
// ----------------------------------------------------------------------------
// tse_back
// Arithmetic pipeline: cross and dot products, squared normal length,
// leading-zero normalization, restoring reciprocal division and rounding.
// ----------------------------------------------------------------------------
module tse_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tse_pkg::tse_edges_t q_rdata,
  output logic                q_pop,
  input  logic                take,
  output logic                tail_valid,
  output tse_pkg::tse_tri_t   tail_data
);
  import tse_pkg::*;

  logic en;

  logic                     s1_v_r;
  tse_edges_t               s1_e_r;
  logic signed [PROD_W-1:0] p_r [15];

  logic                     s2_v_r;
  tse_early_t               s2_r;

  logic                     s3_v_r;
  tse_early_t               s3_r;
  logic [MAG_W-1:0]         hh_r [3];
  logic [MAG_W-1:0]         hl_r [3];
  logic [MAG_W-1:0]         ll_r [3];

  logic                     s4_v_r;
  tse_early_t               s4_r;
  logic [DEN_W-1:0]         sq_r [3];

  logic                     s5_v_r;
  tse_early_t               s5_r;
  logic [DEN_W-1:0]         den_r;

  logic                     nv_r [NORM_STEPS];
  tse_div_t                 nd_r [NORM_STEPS];
  logic                     dv_r [DIV_STEPS];
  tse_div_t                 dd_r [DIV_STEPS];

  logic                     t_v_r;
  tse_tri_t                 t_r;

  logic signed [MAG_W:0]    nsel [3];
  logic [MAG_W-1:0]         mag [3];
  logic [Q_W:0]             qr;
  logic signed [EXP_W:0]    ex0;

  assign en         = !t_v_r || take;
  assign q_pop      = en && q_valid;
  assign tail_valid = t_v_r;
  assign tail_data  = t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      t_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      t_v_r  <= dv_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e_r <= q_rdata;
      p_r[0]  <= q_rdata.uy * q_rdata.vz;
      p_r[1]  <= q_rdata.uz * q_rdata.vy;
      p_r[2]  <= q_rdata.uz * q_rdata.vx;
      p_r[3]  <= q_rdata.ux * q_rdata.vz;
      p_r[4]  <= q_rdata.ux * q_rdata.vy;
      p_r[5]  <= q_rdata.uy * q_rdata.vx;
      p_r[6]  <= q_rdata.ux * q_rdata.ux;
      p_r[7]  <= q_rdata.uy * q_rdata.uy;
      p_r[8]  <= q_rdata.uz * q_rdata.uz;
      p_r[9]  <= q_rdata.ux * q_rdata.vx;
      p_r[10] <= q_rdata.uy * q_rdata.vy;
      p_r[11] <= q_rdata.uz * q_rdata.vz;
      p_r[12] <= q_rdata.vx * q_rdata.vx;
      p_r[13] <= q_rdata.vy * q_rdata.vy;
      p_r[14] <= q_rdata.vz * q_rdata.vz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.e   <= s1_e_r;
      s2_r.nx  <= VAL_W'(p_r[0]) - VAL_W'(p_r[1]);
      s2_r.ny  <= VAL_W'(p_r[2]) - VAL_W'(p_r[3]);
      s2_r.nz  <= VAL_W'(p_r[4]) - VAL_W'(p_r[5]);
      s2_r.d11 <= VAL_W'(p_r[6]) + VAL_W'(p_r[7]) + VAL_W'(p_r[8]);
      s2_r.d12 <= VAL_W'(p_r[9]) + VAL_W'(p_r[10]) + VAL_W'(p_r[11]);
      s2_r.d22 <= VAL_W'(p_r[12]) + VAL_W'(p_r[13]) + VAL_W'(p_r[14]);
    end
  end

  always_comb begin
    nsel[0] = s2_r.nx;
    nsel[1] = s2_r.ny;
    nsel[2] = s2_r.nz;
    for (int k = 0; k < 3; k++) begin
      mag[k] = nsel[k][MAG_W] ? MAG_W'(-nsel[k]) : MAG_W'(nsel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s2_r;
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= mag[k][MAG_W-1:HALF_W] * mag[k][MAG_W-1:HALF_W];
        hl_r[k] <= mag[k][MAG_W-1:HALF_W] * mag[k][HALF_W-1:0];
        ll_r[k] <= mag[k][HALF_W-1:0] * mag[k][HALF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s3_r;
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (DEN_W'(hh_r[k]) << (2*HALF_W)) + (DEN_W'(hl_r[k]) << (HALF_W+1))
                   + DEN_W'(ll_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r  <= s4_r;
      den_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - k);
    logic             v_in;
    tse_div_t         d_in;
    tse_div_t         d_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        v_in        = s5_v_r;
        d_in        = '0;
        d_in.early  = s5_r;
        d_in.den    = den_r;
        d_in.deg    = (den_r == '0);
      end
    end else begin : g_next
      assign v_in = nv_r[k-1];
      assign d_in = nd_r[k-1];
    end

    always_comb begin
      d_nxt = d_in;
      if (d_in.den[DEN_W-1 -: SH] == '0) begin
        d_nxt.den = d_in.den << SH;
        d_nxt.lz  = d_in.lz + LZ_W'(SH);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[k] <= 1'b0;
      end else if (en) begin
        nv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nd_r[k] <= d_nxt;
      end
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic             v_in;
    tse_div_t         d_in;
    tse_div_t         d_nxt;
    logic [REM_W-1:0] r;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in = nv_r[NORM_STEPS-1];
      assign d_in = nd_r[NORM_STEPS-1];
      assign r    = REM_W'(1) << (DEN_W - 1);
    end else begin : g_next
      assign v_in = dv_r[i-1];
      assign d_in = dd_r[i-1];
      assign r    = d_in.rem << 1;
    end

    always_comb begin
      ge        = (r >= REM_W'(d_in.den));
      d_nxt     = d_in;
      d_nxt.rem = ge ? (r - REM_W'(d_in.den)) : r;
      d_nxt.q   = {d_in.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else if (en) begin
        dv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[i] <= d_nxt;
      end
    end
  end

  always_comb begin
    qr  = ((Q_W+1)'(dd_r[DIV_STEPS-1].q) + (Q_W+1)'(1)) >> 1;
    ex0 = $signed({1'b0, dd_r[DIV_STEPS-1].lz}) - (EXP_W+1)'(EXP_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r.early <= dd_r[DIV_STEPS-1].early;
      t_r.deg   <= dd_r[DIV_STEPS-1].deg;
      priority if (dd_r[DIV_STEPS-1].deg) begin
        t_r.mant <= '0;
        t_r.ex   <= '0;
      end else if (qr[MANT_W-1]) begin
        t_r.mant <= MANT_W'(1) << (MANT_W - 2);
        t_r.ex   <= EXP_W'(ex0 + (EXP_W+1)'(1));
      end else begin
        t_r.mant <= qr[MANT_W-1:0];
        t_r.ex   <= EXP_W'(ex0);
      end
    end
  end

endmodule

### rtl/tse_out.sv
// ----------------------------------------------------------------------------
// tse_out
// Result slot: holds one finished triangle and sends its five beats in order.
// ----------------------------------------------------------------------------
module tse_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tail_valid,
  input  tse_pkg::tse_tri_t tail_data,
  output logic              take,
  tse_out_if.source         out_chan
);
  import tse_pkg::*;

  tse_tri_t          tri_r;
  logic              busy_r;
  logic [PART_W-1:0] idx_r;
  logic              last_beat;

  assign last_beat = busy_r && out_chan.ready && (idx_r == PART_RECIP);
  assign take      = tail_valid && (!busy_r || last_beat);

  always_ff @(posedge clk) begin
    if (take) begin
      tri_r <= tail_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= PART_EDGE_AB;
    end else if (take) begin
      busy_r <= 1'b1;
      idx_r  <= PART_EDGE_AB;
    end else if (last_beat) begin
      busy_r <= 1'b0;
      idx_r  <= PART_EDGE_AB;
    end else if (busy_r && out_chan.ready) begin
      idx_r  <= idx_r + PART_W'(1);
    end
  end

  assign out_chan.valid = busy_r;
  assign out_chan.part  = idx_r;

  always_comb begin
    out_chan.scale_exponent = '0;
    out_chan.degenerate     = 1'b0;
    out_chan.batch_end      = 1'b0;
    out_chan.last_of_run    = 1'b0;
    unique case (idx_r)
      PART_EDGE_AB: begin
        out_chan.value_one   = VAL_W'(tri_r.early.e.ux);
        out_chan.value_two   = VAL_W'(tri_r.early.e.uy);
        out_chan.value_three = VAL_W'(tri_r.early.e.uz);
      end
      PART_EDGE_AC: begin
        out_chan.value_one   = VAL_W'(tri_r.early.e.vx);
        out_chan.value_two   = VAL_W'(tri_r.early.e.vy);
        out_chan.value_three = VAL_W'(tri_r.early.e.vz);
      end
      PART_NORMAL: begin
        out_chan.value_one   = tri_r.early.nx;
        out_chan.value_two   = tri_r.early.ny;
        out_chan.value_three = tri_r.early.nz;
      end
      PART_DOTS: begin
        out_chan.value_one   = tri_r.early.d11;
        out_chan.value_two   = tri_r.early.d12;
        out_chan.value_three = tri_r.early.d22;
      end
      default: begin
        out_chan.value_one      = $signed({{(VAL_W-MANT_W){1'b0}}, tri_r.mant});
        out_chan.value_two      = '0;
        out_chan.value_three    = '0;
        out_chan.scale_exponent = tri_r.ex;
        out_chan.degenerate     = tri_r.deg;
        out_chan.batch_end      = tri_r.early.e.fin;
        out_chan.last_of_run    = 1'b1;
      end
    endcase
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= PART_RECIP) else $error("result index out of range");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_chan.ready && idx_r != PART_RECIP) |=>
      (busy_r && idx_r == $past(idx_r) + PART_W'(1))) else $error("result beat skipped");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && tri_r.deg) |-> (tri_r.mant == '0 && tri_r.ex == '0))
    else $error("degenerate triangle with nonzero reciprocal");

endmodule

### rtl/triangle_setup_engine_core.sv
// ----------------------------------------------------------------------------
// triangle_setup_engine_core
// Triangle setup: edges, face normal, dot products and a normalized
// reciprocal of the barycentric denominator, five result beats per triangle.
// ----------------------------------------------------------------------------
//   channel   dir  beat                               per triangle
//   in_chan   in   three corners Q8.8 + final flag    1 beat
//   out_chan  out  part, three values, exp, flags     5 beats
//
// Sustained throughput is set by the five result beats per triangle on
// out_chan. A corner beat passes the queue, 5 product/square stages, 7
// normalize stages, 33 restoring divide stages, rounding and the result slot.
// Reset clears all valid state; no clearing pass. A stalled out_chan holds the
// whole pipeline once the rounding stage holds a result; the 4-entry input
// queue keeps taking corner beats until it fills.
// ----------------------------------------------------------------------------
module triangle_setup_engine_core (
  input  logic      clk,
  input  logic      rst_n,
  tse_in_if.sink    in_chan,
  tse_out_if.source out_chan
);
  import tse_pkg::*;

  logic       q_full, q_push, q_pop, q_valid, take, tail_valid;
  tse_edges_t q_wdata, q_rdata;
  tse_tri_t   tail_data;

  tse_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  tse_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  tse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .take       (take),
    .tail_valid (tail_valid),
    .tail_data  (tail_data)
  );

  tse_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (tail_valid),
    .tail_data  (tail_data),
    .take       (take),
    .out_chan   (out_chan)
  );

endmodule
